/* rtl/core/rsq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_pkg
// Shared types and constants of the rotated sprite quad generator.
// ----------------------------------------------------------------------------
package rsq_pkg;

    // Angle resolution in bits; the low bits of the angle below it are dropped.
    localparam int C_ANGLE_BITS = 16;
    localparam logic [15:0] C_PH_MASK = 16'hFFFF << (16 - C_ANGLE_BITS);
    localparam logic [15:0] C_QUARTER_TURN = 16'h4000;

    // Configuration register indexes.
    localparam int C_CFG_IDX_W = 8;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_TEX_WIDTH  = 8'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_TEX_HEIGHT = 8'd1;

    // Corner codes.
    localparam logic [1:0] C_CORNER_LAST = 2'd3;

    // Sine series: t * C_QS_SCALE is the angle in radians in Q30.
    localparam logic [16:0] C_QS_SCALE = 17'd102944;
    localparam int C_SIN_TERMS = 5;
    // Exact floor division of a 32-bit value by 6, 20, 42, 72 and 110:
    // multiply by ceil(2^S/d) and shift right by S.
    localparam logic [32:0] C_DIV_M [C_SIN_TERMS] = '{
        33'd5726623062, 33'd6871947674, 33'd6544712071,
        33'd7635497416, 33'd4997780127
    };
    localparam int C_DIV_S [C_SIN_TERMS] = '{35, 37, 38, 39, 39};

    // Values that travel beside the arithmetic through the whole pipeline.
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [15:0]        cl;
        logic [15:0]        ct;
        logic [15:0]        cr;
        logic [15:0]        cb;
        logic [31:0]        color;
        logic               rot;
    } t_carry;

    // Quad geometry relative to the anchor.
    typedef struct packed {
        logic signed [43:0] a0;
        logic signed [43:0] b0;
        logic signed [43:0] w;
        logic signed [43:0] h;
    } t_geo;

    function automatic logic signed [31:0] f_sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -50'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

endpackage

/* rtl/core/rsq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_if
// Channel interfaces: sprite input, vertex output and configuration writes.
// ----------------------------------------------------------------------------
interface rsq_spr_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [15:0]        clip_left;
    logic [15:0]        clip_top;
    logic [15:0]        clip_right;
    logic [15:0]        clip_bottom;
    logic [15:0]        angle;
    logic [31:0]        color;

    modport source (
        output valid, pos_x, pos_y, scale_x, scale_y, origin_x, origin_y,
               clip_left, clip_top, clip_right, clip_bottom, angle, color,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, scale_x, scale_y, origin_x, origin_y,
               clip_left, clip_top, clip_right, clip_bottom, angle, color,
        output ready
    );
endinterface

interface rsq_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [31:0]        vertex_color;
    logic [1:0]         corner;
    logic               last;

    modport source (
        output valid, vertex_x, vertex_y, tex_u, tex_v, vertex_color, corner, last,
        input  ready
    );
    modport sink (
        input  valid, vertex_x, vertex_y, tex_u, tex_v, vertex_color, corner, last,
        output ready
    );
endinterface

interface rsq_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rsq_pkg::C_CFG_IDX_W-1:0]  index;
    logic [12:0]                      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/rotated_sprite_quad_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_sprite_quad_generator
// Turns one sprite into the four corner vertices of its rotated quad.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Beat contents
//  ---------+-----+--------------------------------------------------------
//  i_cfg    | in  | register index, 13-bit value (texture width / height)
//  i_spr    | in  | one sprite: anchor, scale, origin, clip, angle, color
//  o_vtx    | out | one corner vertex; four beats per sprite, last on the 4th
//
// A sprite passes 17 register stages and then sits in the output buffer,
// which sends its four vertex beats on consecutive cycles while o_vtx is
// ready. The output port limits the sustained rate, as each sprite takes
// four beats; the stages ahead keep taking sprites while the buffer
// drains, until they are all full. Reset clears the valid bits and the
// output buffer's valid flag, and sets the texture size to 1x1.
// Each stage moves only when the one after it is empty or moving, so a stall
// on o_vtx holds every beat in place without loss or repetition.
// ----------------------------------------------------------------------------
module rotated_sprite_quad_generator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rsq_cfg_if.sink   i_cfg,
    rsq_spr_if.sink   i_spr,
    rsq_vtx_if.source o_vtx
);
    import rsq_pkg::*;

    // Stage map:
    //   0      capture, angle quantized
    //   1      texel extent, sine argument folded into the first quadrant
    //   2      extent times scale, series argument x
    //   3      quad size, origin offset product, x squared
    //   4..13  odd Taylor terms: a multiply stage then a divide stage each
    //   14     sine and cosine in signed Q2.15
    //   15     rotation products
    //   16     corner sums, then the output buffer rounds and saturates
    localparam int LP_DEPTH = 17;

    // Configuration registers.
    logic [12:0] r_tex_w;
    logic [12:0] r_tex_h;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_w <= 13'd1;
            r_tex_h <= 13'd1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                C_REG_TEX_WIDTH:  r_tex_w <= i_cfg.data;
                C_REG_TEX_HEIGHT: r_tex_h <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Pipeline flow control: a stage takes new contents when it is empty or
    // when the stage after it takes its contents.
    logic [LP_DEPTH-1:0] r_v;
    logic [LP_DEPTH-1:0] n_en;
    logic                n_ob_free;
    logic                r_ob_vld;
    logic [1:0]          r_beat;

    assign n_ob_free = !r_ob_vld || (o_vtx.ready && (r_beat == C_CORNER_LAST));

    always_comb begin
        n_en[LP_DEPTH-1] = !r_v[LP_DEPTH-1] || n_ob_free;
        for (int i = LP_DEPTH - 2; i >= 0; i--) begin
            n_en[i] = !r_v[i] || n_en[i+1];
        end
    end

    assign i_spr.ready = n_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (n_en[0]) begin
                r_v[0] <= i_spr.valid;
            end
            for (int i = 1; i < LP_DEPTH; i++) begin
                if (n_en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // Payload registers.
    t_carry             r_cy [LP_DEPTH];
    logic signed [15:0] r0_sx, r0_sy, r0_ogx, r0_ogy;
    logic [15:0]        r0_ph;
    logic signed [30:0] r1_ex, r1_ey;
    logic signed [15:0] r1_sx, r1_sy, r1_ogx, r1_ogy;
    logic [14:0]        r1_t [2];
    logic               r1_neg [2];
    logic signed [46:0] r2_exsx, r2_eysy;
    logic signed [15:0] r2_ogx, r2_ogy;
    logic [30:0]        r2_x [2];
    logic               r2_neg [2];
    logic signed [43:0] r3_w, r3_h;
    logic signed [62:0] r3_oxp, r3_oyp;
    logic [31:0]        r_x2  [3:12][2];
    logic [31:0]        r_trm [3:12][2];
    logic signed [33:0] r_sum [3:13][2];
    logic               r_neg [3:13][2];
    t_geo               r_geo [4:14];
    logic signed [16:0] r14_sc [2];
    logic signed [60:0] r15_pr [8];
    logic signed [63:0] r16_ux [4];
    logic signed [63:0] r16_uy [4];

    // Combinational next values.
    logic [15:0]        n_ph;
    logic signed [16:0] n_cw, n_ch;
    logic [15:0]        n_lp [2];
    logic signed [47:0] n_wr, n_hr;
    logic signed [63:0] n_oxr, n_oyr;
    logic [31:0]        n_dq [C_SIN_TERMS][2];
    logic signed [33:0] n_fin [2];
    logic [18:0]        n_res [2];
    logic [14:0]        n_mag [2];
    logic signed [16:0] n_sc [2];

    assign n_ph = i_spr.angle & C_PH_MASK;
    assign n_cw = signed'({1'b0, r_cy[0].cr}) - signed'({1'b0, r_cy[0].cl});
    assign n_ch = signed'({1'b0, r_cy[0].cb}) - signed'({1'b0, r_cy[0].ct});
    assign n_lp[0] = r0_ph;
    assign n_lp[1] = r0_ph + C_QUARTER_TURN;
    // Sizes round half up; the origin offset too.
    assign n_wr  = 48'(r2_exsx) + 48'sd64;
    assign n_hr  = 48'(r2_eysy) + 48'sd64;
    assign n_oxr = 64'(r3_oxp) + 64'sd1048576;
    assign n_oyr = 64'(r3_oyp) + 64'sd1048576;

    // Divide stages: exact floor division by the series denominators.
    always_comb begin
        logic [64:0] v_p;
        for (int k = 0; k < C_SIN_TERMS; k++) begin
            for (int l = 0; l < 2; l++) begin
                v_p = 65'(r_trm[4+2*k][l]) * 65'(C_DIV_M[k]);
                n_dq[k][l] = 32'(v_p >> C_DIV_S[k]);
            end
        end
    end

    // Final sine: clamp, round to Q15, clamp, apply the quadrant sign. With no
    // rotation the cosine lane becomes exactly one (32768) and the sine zero,
    // so the rotation below leaves the corners untouched.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_fin[l] = (r_sum[13][l] < 0) ? 34'sd0 : r_sum[13][l];
            n_res[l] = 19'((n_fin[l] + 34'sd16384) >>> 15);
            n_mag[l] = (n_res[l] > 19'd32767) ? 15'd32767 : n_res[l][14:0];
            n_sc[l]  = r_neg[13][l] ? -17'(n_mag[l]) : 17'(n_mag[l]);
        end
        if (!r_cy[13].rot) begin
            n_sc[0] = 17'sd0;
            n_sc[1] = 17'sd32768;
        end
    end

    always_ff @(posedge i_clk) begin
        // Stage 0: capture.
        if (n_en[0]) begin
            r_cy[0].px    <= i_spr.pos_x;
            r_cy[0].py    <= i_spr.pos_y;
            r_cy[0].cl    <= i_spr.clip_left;
            r_cy[0].ct    <= i_spr.clip_top;
            r_cy[0].cr    <= i_spr.clip_right;
            r_cy[0].cb    <= i_spr.clip_bottom;
            r_cy[0].color <= i_spr.color;
            r_cy[0].rot   <= |n_ph;
            r0_sx  <= i_spr.scale_x;
            r0_sy  <= i_spr.scale_y;
            r0_ogx <= i_spr.origin_x;
            r0_ogy <= i_spr.origin_y;
            r0_ph  <= n_ph;
        end
        for (int i = 1; i < LP_DEPTH; i++) begin
            if (n_en[i]) begin
                r_cy[i] <= r_cy[i-1];
            end
        end

        // Stage 1: extent in texels times clip size, quadrant folding.
        if (n_en[1]) begin
            r1_ex  <= signed'({1'b0, r_tex_w}) * n_cw;
            r1_ey  <= signed'({1'b0, r_tex_h}) * n_ch;
            r1_sx  <= r0_sx;
            r1_sy  <= r0_sy;
            r1_ogx <= r0_ogx;
            r1_ogy <= r0_ogy;
            for (int l = 0; l < 2; l++) begin
                r1_t[l]   <= n_lp[l][14] ? 15'd16384 - 15'(n_lp[l][13:0])
                                         : 15'(n_lp[l][13:0]);
                r1_neg[l] <= n_lp[l][15];
            end
        end

        // Stage 2: scale the extent, series argument.
        if (n_en[2]) begin
            r2_exsx <= r1_ex * r1_sx;
            r2_eysy <= r1_ey * r1_sy;
            r2_ogx  <= r1_ogx;
            r2_ogy  <= r1_ogy;
            for (int l = 0; l < 2; l++) begin
                r2_x[l]   <= 31'(r1_t[l]) * 31'(C_QS_SCALE);
                r2_neg[l] <= r1_neg[l];
            end
        end

        // Stage 3: quad size, origin product, x squared.
        if (n_en[3]) begin
            r3_w   <= 44'(signed'(n_wr[47:7]));
            r3_h   <= 44'(signed'(n_hr[47:7]));
            r3_oxp <= r2_exsx * r2_ogx;
            r3_oyp <= r2_eysy * r2_ogy;
            for (int l = 0; l < 2; l++) begin
                r_x2[3][l]  <= 32'((64'(r2_x[l]) * 64'(r2_x[l])) >> 30);
                r_trm[3][l] <= 32'(r2_x[l]);
                r_sum[3][l] <= 34'(r2_x[l]);
                r_neg[3][l] <= r2_neg[l];
            end
        end

        // Stage 4: corner offsets from the anchor.
        if (n_en[4]) begin
            r_geo[4].a0 <= -44'(signed'(n_oxr[63:21]));
            r_geo[4].b0 <= -44'(signed'(n_oyr[63:21]));
            r_geo[4].w  <= r3_w;
            r_geo[4].h  <= r3_h;
        end
        for (int i = 5; i <= 14; i++) begin
            if (n_en[i]) begin
                r_geo[i] <= r_geo[i-1];
            end
        end

        // Stages 4..13: each term is the previous one times x squared, then
        // divided by (2k)(2k+1); terms alternate in sign.
        for (int j = 4; j <= 13; j++) begin
            if (n_en[j]) begin
                for (int l = 0; l < 2; l++) begin
                    r_neg[j][l] <= r_neg[j-1][l];
                    if (j <= 12) begin
                        r_x2[j][l] <= r_x2[j-1][l];
                    end
                    if (((j - 4) & 1) == 0) begin
                        r_trm[j][l] <= 32'((64'(r_trm[j-1][l]) * 64'(r_x2[j-1][l])) >> 30);
                        r_sum[j][l] <= r_sum[j-1][l];
                    end else begin
                        if (j <= 12) begin
                            r_trm[j][l] <= n_dq[(j-5)>>1][l];
                        end
                        if ((((j - 5) >> 1) & 1) == 0) begin
                            r_sum[j][l] <= r_sum[j-1][l] - 34'(n_dq[(j-5)>>1][l]);
                        end else begin
                            r_sum[j][l] <= r_sum[j-1][l] + 34'(n_dq[(j-5)>>1][l]);
                        end
                    end
                end
            end
        end

        // Stage 14: sine (lane 0) and cosine (lane 1).
        if (n_en[14]) begin
            r14_sc <= n_sc;
        end

        // Stage 15: rotation products of the base corner and of the width and height edges.
        if (n_en[15]) begin
            r15_pr[0] <= r14_sc[1] * r_geo[14].a0;
            r15_pr[1] <= r14_sc[0] * r_geo[14].b0;
            r15_pr[2] <= r14_sc[1] * r_geo[14].w;
            r15_pr[3] <= r14_sc[0] * r_geo[14].h;
            r15_pr[4] <= r14_sc[0] * r_geo[14].a0;
            r15_pr[5] <= r14_sc[1] * r_geo[14].b0;
            r15_pr[6] <= r14_sc[0] * r_geo[14].w;
            r15_pr[7] <= r14_sc[1] * r_geo[14].h;
        end

        // Stage 16: per corner sums, with the rounding half already added.
        if (n_en[16]) begin
            for (int k = 0; k < 4; k++) begin
                r16_ux[k] <= 64'(r15_pr[0]) - 64'(r15_pr[1]) + 64'sd16384
                           + (((k & 1) != 0) ? 64'(r15_pr[2]) : 64'sd0)
                           - (((k & 2) != 0) ? 64'(r15_pr[3]) : 64'sd0);
                r16_uy[k] <= 64'(r15_pr[4]) + 64'(r15_pr[5]) + 64'sd16384
                           + (((k & 1) != 0) ? 64'(r15_pr[6]) : 64'sd0)
                           + (((k & 2) != 0) ? 64'(r15_pr[7]) : 64'sd0);
            end
        end
    end

    // Output buffer: holds one finished quad and sends its four corners.
    logic signed [31:0] r_ob_x [4];
    logic signed [31:0] r_ob_y [4];
    logic [15:0]        r_ob_cl, r_ob_ct, r_ob_cr, r_ob_cb;
    logic [31:0]        r_ob_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_vld <= 1'b0;
            r_beat   <= '0;
        end else if (n_ob_free) begin
            r_ob_vld <= r_v[LP_DEPTH-1];
            r_beat   <= '0;
        end else if (o_vtx.ready) begin
            r_beat <= r_beat + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_ob_free && r_v[LP_DEPTH-1]) begin
            for (int k = 0; k < 4; k++) begin
                r_ob_x[k] <= f_sat32(50'(signed'(r16_ux[k][63:15]))
                                   + 50'(r_cy[LP_DEPTH-1].px));
                r_ob_y[k] <= f_sat32(50'(signed'(r16_uy[k][63:15]))
                                   + 50'(r_cy[LP_DEPTH-1].py));
            end
            r_ob_cl    <= r_cy[LP_DEPTH-1].cl;
            r_ob_ct    <= r_cy[LP_DEPTH-1].ct;
            r_ob_cr    <= r_cy[LP_DEPTH-1].cr;
            r_ob_cb    <= r_cy[LP_DEPTH-1].cb;
            r_ob_color <= r_cy[LP_DEPTH-1].color;
        end
    end

    assign o_vtx.valid        = r_ob_vld;
    assign o_vtx.vertex_x     = r_ob_x[r_beat];
    assign o_vtx.vertex_y     = r_ob_y[r_beat];
    assign o_vtx.tex_u        = r_beat[0] ? r_ob_cr : r_ob_cl;
    assign o_vtx.tex_v        = r_beat[1] ? r_ob_cb : r_ob_ct;
    assign o_vtx.vertex_color = r_ob_color;
    assign o_vtx.corner       = r_beat;
    assign o_vtx.last         = (r_beat == C_CORNER_LAST);

endmodule

/* rtl/core/rsq_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_chk
// Port checks on the vertex output of the quad generator.
// ----------------------------------------------------------------------------
module rsq_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              i_ready,
    input logic [1:0]        i_corner,
    input logic              i_last,
    input logic signed [31:0] i_vertex_x
);
    import rsq_pkg::*;

    // A stalled beat stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("vertex beat dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_corner) && $stable(i_vertex_x))
        else $error("vertex beat changed while stalled");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_last == (i_corner == C_CORNER_LAST)))
        else $error("last flag does not match the corner");

    // The corners of one quad follow each other without a gap.
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last |=> i_valid && (i_corner == $past(i_corner) + 2'd1))
        else $error("quad corners out of sequence");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("vertex valid after reset");

endmodule

bind rotated_sprite_quad_generator rsq_chk u_rsq_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_vtx.valid),
    .i_ready    (o_vtx.ready),
    .i_corner   (o_vtx.corner),
    .i_last     (o_vtx.last),
    .i_vertex_x (o_vtx.vertex_x)
);
